FILE: rtl/dsf_pkg.sv
package dsf_pkg;

    // Fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 25;
    localparam int BW_CFG_W   = 9;
    localparam int SW_CFG_W   = 7;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 1;

    // Register reset values
    localparam logic [BW_CFG_W-1:0] BW_RESET = 9'd128;
    localparam logic [SW_CFG_W-1:0] SW_RESET = 7'd30;

    // Saturation limits of the detrended output
    localparam int DET_MAX_VAL = 16777215;
    localparam int DET_MIN_VAL = -16777216;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_WIN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_WIN = 1'b1;

    // Divider operand select
    localparam logic DIV_SEL_BASE   = 1'b0;
    localparam logic DIV_SEL_SMOOTH = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic base_upd;
        logic div_start;
        logic div_sel;
        logic det_ld;
        logic sm_wr;
        logic sm_drop;
        logic out_ld;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic base_full;
        logic smooth_full;
        logic div_busy;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/dsf_div.sv
module dsf_div import dsf_pkg::*; #(
    parameter int DW  = 33,
    parameter int DVW = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [DW-1:0] i_dividend,
    input  logic [DVW-1:0]       i_divisor,
    output logic                 o_busy,
    output logic signed [DW-1:0] o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]  r_quo;
    logic [DVW:0]   r_rem;
    logic [DVW-1:0] r_dvs;
    logic [CW-1:0]  r_cnt;
    logic           r_neg;
    logic           r_busy;

    logic [DVW:0]   trial;
    logic           fits;
    logic [DW-1:0]  mag;

    // Dividend magnitude, sign kept apart so the result truncates toward zero
    assign mag   = i_dividend[DW-1] ? DW'(-i_dividend) : DW'(i_dividend);
    assign trial = {r_rem[DVW-1:0], r_quo[DW-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    // Restoring division, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= mag;
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_neg <= i_dividend[DW-1];
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_dvs}) : trial;
            r_quo <= {r_quo[DW-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_neg ? $signed(-r_quo) : $signed(r_quo);

endmodule

FILE: rtl/dsf_datapath.sv
module dsf_datapath import dsf_pkg::*; #(
    parameter int BASE_DEPTH   = 256,
    parameter int SMOOTH_DEPTH = 64,
    parameter int FRAC_BITS    = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    output t_sts                        o_sts,
    input  logic signed [SAMPLE_W-1:0]  i_sample,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic signed [OUT_W-1:0]     o_detrended,
    output logic signed [OUT_W-1:0]     o_smoothed,
    output logic                        o_smoothed_valid
);

    localparam int BAW    = $clog2(BASE_DEPTH);
    localparam int SAW    = (SMOOTH_DEPTH > 1) ? $clog2(SMOOTH_DEPTH) : 1;
    localparam int BCW    = $clog2(BASE_DEPTH + 1);
    localparam int SCW    = $clog2(SMOOTH_DEPTH + 1);
    localparam int BSW    = BCW + 1;
    localparam int SSW    = ((SCW > SAW) ? SCW : SAW) + 1;
    localparam int SUM_BW = SAMPLE_W + $clog2(BASE_DEPTH) + 1;
    localparam int SSUM_W = OUT_W + $clog2(SMOOTH_DEPTH) + 1;
    localparam int DW     = ((SUM_BW + FRAC_BITS) > SSUM_W) ? (SUM_BW + FRAC_BITS) : SSUM_W;
    localparam int DVW    = (BCW > SCW) ? BCW : SCW;
    localparam int DTW    = DW + 2;

    localparam logic signed [DTW-1:0] DET_MAX = DTW'(DET_MAX_VAL);
    localparam logic signed [DTW-1:0] DET_MIN = DTW'(DET_MIN_VAL);

    // Configuration
    logic [BW_CFG_W-1:0] r_cfg_bw;
    logic [SW_CFG_W-1:0] r_cfg_sw;

    // Window state
    logic [BAW-1:0]           r_bhead, n_bhead;
    logic [BCW-1:0]           r_bcnt, n_bcnt;
    logic signed [SUM_BW-1:0] r_bsum, n_bsum;
    logic [SAW-1:0]           r_shead, n_shead;
    logic [SCW-1:0]           r_scnt, n_scnt;
    logic signed [SSUM_W-1:0] r_ssum, n_ssum;

    // Memories and read registers
    logic signed [SAMPLE_W-1:0] r_bmem [BASE_DEPTH];
    logic signed [OUT_W-1:0]    r_smem [SMOOTH_DEPTH];
    logic signed [SAMPLE_W-1:0] r_brd;
    logic signed [OUT_W-1:0]    r_srd;

    // Item working registers
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [OUT_W-1:0]    r_det;
    logic                       r_svalid;
    logic                       r_old_new;

    // Output register
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out_det;
    logic signed [OUT_W-1:0] r_out_sm;
    logic                    r_out_sv;

    logic [31:0]     bw_x, sw_x, bw_c, sw_c;
    logic [BCW-1:0]  bw_eff;
    logic [SCW-1:0]  sw_eff;
    logic [BSW-1:0]  bslot_x;
    logic [BAW-1:0]  bslot, bhead_inc;
    logic [SSW-1:0]  sslot_x;
    logic [SAW-1:0]  sslot, shead_inc;
    logic            base_full, smooth_full;

    logic signed [DW-1:0]    bdvd, sdvd, quo;
    logic                    div_busy;
    logic signed [DTW-1:0]   det_wide;
    logic signed [OUT_W-1:0] det_sat;
    logic signed [OUT_W-1:0] s_old;

    // Window lengths clamped to what the stores hold
    always_comb begin
        bw_x = 32'(r_cfg_bw);
        sw_x = 32'(r_cfg_sw);
        if (bw_x < 32'd2) begin
            bw_c = 32'd2;
        end else if (bw_x > 32'(BASE_DEPTH)) begin
            bw_c = 32'(BASE_DEPTH);
        end else begin
            bw_c = bw_x;
        end
        if (sw_x < 32'd1) begin
            sw_c = 32'd1;
        end else if (sw_x > 32'(SMOOTH_DEPTH)) begin
            sw_c = 32'(SMOOTH_DEPTH);
        end else begin
            sw_c = sw_x;
        end
        bw_eff = BCW'(bw_c);
        sw_eff = SCW'(sw_c);
    end

    // Ring addresses: tail slot and next head, wrapping at the depth
    always_comb begin
        bslot_x = BSW'(r_bhead) + BSW'(r_bcnt);
        if (bslot_x >= BSW'(BASE_DEPTH)) begin
            bslot_x = bslot_x - BSW'(BASE_DEPTH);
        end
        bslot     = bslot_x[BAW-1:0];
        bhead_inc = (r_bhead == BAW'(BASE_DEPTH - 1)) ? '0 : r_bhead + BAW'(1);

        sslot_x = SSW'(r_shead) + SSW'(r_scnt);
        if (sslot_x >= SSW'(SMOOTH_DEPTH)) begin
            sslot_x = sslot_x - SSW'(SMOOTH_DEPTH);
        end
        sslot     = sslot_x[SAW-1:0];
        shead_inc = (r_shead == SAW'(SMOOTH_DEPTH - 1)) ? '0 : r_shead + SAW'(1);
    end

    assign base_full   = (BSW'(r_bcnt) + BSW'(1)) >= BSW'(bw_eff);
    assign smooth_full = (SSW'(r_scnt) + SSW'(1)) >= SSW'(sw_eff);

    // Oldest smoothing value; with an empty window it is the one just written
    assign s_old = r_old_new ? r_det : r_srd;

    // Next window state
    always_comb begin
        n_bhead = r_bhead;
        n_bcnt  = r_bcnt;
        n_bsum  = r_bsum;
        n_shead = r_shead;
        n_scnt  = r_scnt;
        n_ssum  = r_ssum;
        if (i_cfg_we) begin
            n_bhead = '0;
            n_bcnt  = '0;
            n_bsum  = '0;
            n_shead = '0;
            n_scnt  = '0;
            n_ssum  = '0;
        end else begin
            if (i_cmd.base_upd) begin
                if (base_full) begin
                    n_bsum  = r_bsum + SUM_BW'(r_sample) - SUM_BW'(r_brd);
                    n_bhead = bhead_inc;
                end else begin
                    n_bsum = r_bsum + SUM_BW'(r_sample);
                    n_bcnt = r_bcnt + BCW'(1);
                end
            end
            if (i_cmd.sm_wr) begin
                n_ssum = r_ssum + SSUM_W'(r_det);
                if (!smooth_full) begin
                    n_scnt = r_scnt + SCW'(1);
                end
            end
            if (i_cmd.sm_drop) begin
                n_ssum  = r_ssum - SSUM_W'(s_old);
                n_shead = shead_inc;
            end
        end
    end

    // Config and window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_bw <= BW_RESET;
            r_cfg_sw <= SW_RESET;
            r_bhead  <= '0;
            r_bcnt   <= '0;
            r_bsum   <= '0;
            r_shead  <= '0;
            r_scnt   <= '0;
            r_ssum   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BASE_WIN:   r_cfg_bw <= i_cfg_data[BW_CFG_W-1:0];
                    CFG_SMOOTH_WIN: r_cfg_sw <= i_cfg_data[SW_CFG_W-1:0];
                    default:        ;
                endcase
            end
            r_bhead <= n_bhead;
            r_bcnt  <= n_bcnt;
            r_bsum  <= n_bsum;
            r_shead <= n_shead;
            r_scnt  <= n_scnt;
            r_ssum  <= n_ssum;
        end
    end

    // Baseline store: new sample at the tail, oldest read at the head
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_bmem[bslot] <= i_sample;
            r_brd         <= r_bmem[r_bhead];
            r_sample      <= i_sample;
        end
    end

    // Smoothing store
    always_ff @(posedge i_clk) begin
        if (i_cmd.sm_wr) begin
            r_smem[sslot] <= r_det;
            r_srd         <= r_smem[r_shead];
            r_svalid      <= smooth_full;
            r_old_new     <= (r_scnt == '0);
        end
    end

    // Shared divider: baseline mean, then smoothing mean
    assign bdvd = DW'(r_bsum) <<< FRAC_BITS;
    assign sdvd = DW'(r_ssum);

    dsf_div #(
        .DW  (DW),
        .DVW (DVW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ((i_cmd.div_sel == DIV_SEL_SMOOTH) ? sdvd : bdvd),
        .i_divisor  ((i_cmd.div_sel == DIV_SEL_SMOOTH) ? DVW'(sw_eff)
                                                       : DVW'(bw_eff - BCW'(1))),
        .o_busy     (div_busy),
        .o_quotient (quo)
    );

    // Detrended value, saturated to the output range
    always_comb begin
        det_wide = (DTW'(r_sample) <<< FRAC_BITS) - DTW'(quo);
        if (det_wide > DET_MAX) begin
            det_sat = OUT_W'(DET_MAX);
        end else if (det_wide < DET_MIN) begin
            det_sat = OUT_W'(DET_MIN);
        end else begin
            det_sat = OUT_W'(det_wide);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.det_ld) begin
            r_det <= det_sat;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_det <= r_det;
            r_out_sm  <= r_svalid ? OUT_W'(quo) : '0;
            r_out_sv  <= r_svalid;
        end
    end

    assign o_sts.base_full   = base_full;
    assign o_sts.smooth_full = smooth_full;
    assign o_sts.div_busy    = div_busy;
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_detrended      = r_out_det;
    assign o_smoothed       = r_out_sm;
    assign o_smoothed_valid = r_out_sv;

endmodule

FILE: rtl/dsf_ctrl.sv
module dsf_ctrl import dsf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_BASE   = 4'd1;
    localparam logic [3:0] S_BSTART = 4'd2;
    localparam logic [3:0] S_BDIV   = 4'd3;
    localparam logic [3:0] S_DET    = 4'd4;
    localparam logic [3:0] S_SWR    = 4'd5;
    localparam logic [3:0] S_SSTART = 4'd6;
    localparam logic [3:0] S_SDIV   = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0] r_state, n_state;

    // Sequencing of one item
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_BASE;
                end
            end
            S_BASE: begin
                o_cmd.base_upd = 1'b1;
                n_state = i_sts.base_full ? S_BSTART : S_IDLE;
            end
            S_BSTART: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_SEL_BASE;
                n_state         = S_BDIV;
            end
            S_BDIV: begin
                o_cmd.div_sel = DIV_SEL_BASE;
                if (!i_sts.div_busy) begin
                    n_state = S_DET;
                end
            end
            S_DET: begin
                o_cmd.det_ld = 1'b1;
                n_state      = S_SWR;
            end
            S_SWR: begin
                o_cmd.sm_wr = 1'b1;
                n_state = i_sts.smooth_full ? S_SSTART : S_OUT;
            end
            S_SSTART: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_SEL_SMOOTH;
                n_state         = S_SDIV;
            end
            S_SDIV: begin
                o_cmd.div_sel = DIV_SEL_SMOOTH;
                if (!i_sts.div_busy) begin
                    o_cmd.sm_drop = 1'b1;
                    n_state       = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: rtl/detrend_and_smooth_filter_unit.sv
// Detrend and smooth filter. Each sample item enters a baseline window of
// baseline_window samples. Once that window is full, every item gives one
// result. The result holds the sample minus the mean of the latest
// baseline_window-1 samples (8 fractional bits by default, saturated to
// 25 bits). It also holds the moving average of the last smooth_window
// detrended values, with a flag that says whether the smoothing window was
// full. Until the baseline window fills, an item gives no result. Both
// means go through one shared restoring divider that retires one quotient
// bit a cycle, DW being the divider width (33 with the default
// parameters). While the smoothing window fills, an item with a result
// runs one division; once the smoothing window is full it runs two. A
// finished result waits while the output is stalled, and no new item is
// taken until it is loaded. Any configuration write empties both windows.
module detrend_and_smooth_filter_unit import dsf_pkg::*; #(
    parameter int BASE_DEPTH   = 256,
    parameter int SMOOTH_DEPTH = 64,
    parameter int FRAC_BITS    = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [OUT_W-1:0]    o_detrended,
    output logic signed [OUT_W-1:0]    o_smoothed,
    output logic                       o_smoothed_valid,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    dsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    dsf_datapath #(
        .BASE_DEPTH   (BASE_DEPTH),
        .SMOOTH_DEPTH (SMOOTH_DEPTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_sample         (i_sample),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_detrended      (o_detrended),
        .o_smoothed       (o_smoothed),
        .o_smoothed_valid (o_smoothed_valid)
    );

    // No item is taken while a division runs
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.div_busy |-> o_in_stall)
        else $error("item accepted during division");

    // A division start always leaves the divider busy
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |=> w_sts.div_busy)
        else $error("divider did not start");

    // A loaded result is presented on the next cycle
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_ld |=> o_out_valid)
        else $error("result load lost");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import dsf_pkg::*;

    localparam int BASE_DEPTH   = 256;
    localparam int SMOOTH_DEPTH = 64;
    localparam int FRAC_BITS    = 8;
    localparam int DRAIN_CYCLES = 100;
    localparam int QUIET_LIMIT  = 3000;
    localparam int IDLE_PCT     = 13;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic signed [OUT_W-1:0] det;
        logic signed [OUT_W-1:0] sm;
        logic                    sm_ok;
    } filt_res_t;

    // One row of the directed stimulus: a register write or a sample item
    typedef struct {
        bit                         is_cfg;
        logic [CFG_IDX_W-1:0]       idx;
        logic [CFG_DATA_W-1:0]      data;
        logic signed [SAMPLE_W-1:0] smp;
        bit                         typed;   // expectation written in the row
        bit                         gives;   // typed row yields a result
        filt_res_t                  res;
    } stim_row_t;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic signed [OUT_W-1:0]    o_detrended;
    logic signed [OUT_W-1:0]    o_smoothed;
    logic                       o_smoothed_valid;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CFG_DATA_W-1:0]      i_cfg_data;

    detrend_and_smooth_filter_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_sample         (i_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_detrended      (o_detrended),
        .o_smoothed       (o_smoothed),
        .o_smoothed_valid (o_smoothed_valid),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    filt_res_t filtered_q[$];
    int        n_err;
    int        quiet_cycles;
    bit        idle_on;
    int        drift;

    // Filter state mirrored for prediction
    logic [BW_CFG_W-1:0]        base_win_reg;
    logic [SW_CFG_W-1:0]        smooth_win_reg;
    logic signed [SAMPLE_W-1:0] base_ring [BASE_DEPTH];
    longint                     smooth_ring [SMOOTH_DEPTH];
    int                         base_head, base_cnt, smooth_head, smooth_cnt;
    longint                     base_sum, smooth_sum;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic clear_windows();
        base_head   = 0;
        base_cnt    = 0;
        base_sum    = 0;
        smooth_head = 0;
        smooth_cnt  = 0;
        smooth_sum  = 0;
    endtask

    // Baseline removal then smoothing for one accepted sample
    task automatic filter_sample(input logic signed [SAMPLE_W-1:0] s, output bit gives,
                                 output filt_res_t r);
        int     bw, sw;
        longint scale, mean, det;
        bw = (base_win_reg < 2) ? 2 :
             (base_win_reg > BASE_DEPTH) ? BASE_DEPTH : int'(base_win_reg);
        sw = (smooth_win_reg < 1) ? 1 :
             (smooth_win_reg > SMOOTH_DEPTH) ? SMOOTH_DEPTH : int'(smooth_win_reg);
        scale   = longint'(1) << FRAC_BITS;
        gives   = 1'b0;
        r.det   = '0;
        r.sm    = '0;
        r.sm_ok = 1'b0;
        base_ring[(base_head + base_cnt) % BASE_DEPTH] = s;
        base_cnt++;
        base_sum += s;
        if (base_cnt >= bw) begin
            gives = 1'b1;
            base_sum -= base_ring[base_head];
            base_head = (base_head + 1) % BASE_DEPTH;
            base_cnt--;
            mean = (base_sum * scale) / base_cnt;
            det  = longint'(s) * scale - mean;
            if (det > DET_MAX_VAL) det = DET_MAX_VAL;
            if (det < DET_MIN_VAL) det = DET_MIN_VAL;
            r.det = OUT_W'(det);
            smooth_ring[(smooth_head + smooth_cnt) % SMOOTH_DEPTH] = det;
            smooth_cnt++;
            smooth_sum += det;
            if (smooth_cnt >= sw) begin
                r.sm    = OUT_W'(smooth_sum / sw);
                r.sm_ok = 1'b1;
                smooth_sum -= smooth_ring[smooth_head];
                smooth_head = (smooth_head + 1) % SMOOTH_DEPTH;
                smooth_cnt--;
            end
        end
    endtask

    // Register write; the caller lowers the enable once the writes are done
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx == CFG_BASE_WIN) base_win_reg = data[BW_CFG_W-1:0];
        else smooth_win_reg = data[SW_CFG_W-1:0];
        clear_windows();
        @(negedge i_clk);
    endtask

    // Wait until every result is in and the block has finished any fill item
    task automatic settle();
        i_in_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Offer one sample item; called and left at a falling edge
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input bit typed,
                               input bit gives, input filt_res_t res);
        bit        got;
        filt_res_t r;
        i_cfg_we <= 1'b0;
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do @(posedge i_clk); while (o_in_stall);
        filter_sample(s, got, r);
        if (typed) begin
            got = gives;
            r   = res;
        end
        if (got) filtered_q.insert(filtered_q.size(), r);
        @(negedge i_clk);
    endtask

    // Half the samples follow a wandering sensor trace, with extremes and raw noise mixed in
    task automatic draw_sample(output logic signed [SAMPLE_W-1:0] s);
        int pick, v;
        pick = $urandom_range(99);
        if (pick < 50) begin
            drift += int'($urandom_range(400)) - 200;
            if (drift > 32000) drift = 32000;
            if (drift < -32000) drift = -32000;
            v = drift + int'($urandom_range(64)) - 32;
            s = SAMPLE_W'(v);
        end else if (pick < 65) begin
            case ($urandom_range(3))
                0:       s = -16'sd32768;
                1:       s = 16'sd32767;
                2:       s = 16'sd0;
                default: s = -16'sd1;
            endcase
        end else begin
            s = SAMPLE_W'($urandom);
        end
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] bw_data,
                             input logic [CFG_DATA_W-1:0] sw_data,
                             input int n_items, input bit calm);
        logic signed [SAMPLE_W-1:0] s;
        filt_res_t                  unused;
        unused = '{default: '0};
        settle();
        if ($urandom_range(1)) begin
            write_reg(CFG_BASE_WIN, bw_data);
            write_reg(CFG_SMOOTH_WIN, sw_data);
        end else begin
            write_reg(CFG_SMOOTH_WIN, sw_data);
            write_reg(CFG_BASE_WIN, bw_data);
        end
        idle_on = !calm;
        repeat (n_items) begin
            draw_sample(s);
            push_sample(s, 1'b0, 1'b0, unused);
        end
        idle_on = 1'b1;
    endtask

    function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        return row;
    endfunction

    function automatic stim_row_t item_row(int s);
        stim_row_t row;
        row     = '{default: '0};
        row.smp = SAMPLE_W'(s);
        return row;
    endfunction

    // Item whose outcome is typed in: no result, or the given fields
    function automatic stim_row_t quiet_row(int s);
        stim_row_t row;
        row       = item_row(s);
        row.typed = 1'b1;
        return row;
    endfunction

    function automatic stim_row_t typed_row(int s, int det, int sm, bit ok);
        stim_row_t row;
        row           = quiet_row(s);
        row.gives     = 1'b1;
        row.res.det   = OUT_W'(det);
        row.res.sm    = OUT_W'(sm);
        row.res.sm_ok = ok;
        return row;
    endfunction

    // Receiver stalls
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Result checker
    always @(posedge i_clk) begin : check_results
        filt_res_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (filtered_q.size() == 0) begin
                n_err++;
                if (n_err <= MAX_REPORTS)
                    $display("unexpected result: det %0d sm %0d sm_valid %0b",
                             o_detrended, o_smoothed, o_smoothed_valid);
            end else begin
                want = filtered_q[0];
                filtered_q.delete(0);
                if (o_detrended !== want.det || o_smoothed !== want.sm ||
                    o_smoothed_valid !== want.sm_ok) begin
                    n_err++;
                    if (n_err <= MAX_REPORTS)
                        $display("mismatch: det %0d/%0d sm %0d/%0d sm_valid %0b/%0b (exp/got)",
                                 want.det, o_detrended, want.sm, o_smoothed,
                                 want.sm_ok, o_smoothed_valid);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake and no register write
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        stim_row_t rows[$];
        bit        after_item;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_sample     = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        idle_on      = 1'b1;
        drift        = 0;
        n_err        = 0;
        quiet_cycles = 0;
        base_win_reg   = BW_RESET;
        smooth_win_reg = SW_RESET;
        clear_windows();

        // Two-sample window: the mean is the sample itself, so the output is 0
        rows = {rows, cfg_row(CFG_BASE_WIN, 9'd2)};
        rows = {rows, cfg_row(CFG_SMOOTH_WIN, 9'd1)};
        rows = {rows, quiet_row(-32768)};
        rows = {rows, typed_row(32767, 0, 0, 1'b1)};
        rows = {rows, typed_row(0, 0, 0, 1'b1)};
        rows = {rows, typed_row(-1, 0, 0, 1'b1)};
        // Three-sample window: det is half the step times 256
        rows = {rows, cfg_row(CFG_BASE_WIN, 9'd3)};
        rows = {rows, quiet_row(0)};
        rows = {rows, quiet_row(-32768)};
        rows = {rows, typed_row(32767, 8388480, 8388480, 1'b1)};
        rows = {rows, typed_row(-32768, -8388480, -8388480, 1'b1)};
        rows = {rows, typed_row(0, 4194304, 4194304, 1'b1)};
        // Window registers below range clamp to 2 and 1
        rows = {rows, cfg_row(CFG_SMOOTH_WIN, 9'd0)};
        rows = {rows, cfg_row(CFG_BASE_WIN, 9'd0)};
        rows = {rows, quiet_row(5)};
        rows = {rows, typed_row(-7, 0, 0, 1'b1)};
        rows = {rows, cfg_row(CFG_BASE_WIN, 9'd1)};
        rows = {rows, quiet_row(123)};
        rows = {rows, typed_row(-123, 0, 0, 1'b1)};
        // Smoothing window of two: first result not yet smoothed
        rows = {rows, cfg_row(CFG_SMOOTH_WIN, 9'd2)};
        rows = {rows, cfg_row(CFG_BASE_WIN, 9'd3)};
        rows = {rows, quiet_row(0)};
        rows = {rows, quiet_row(50)};
        rows = {rows, typed_row(100, 6400, 0, 1'b0)};
        rows = {rows, typed_row(300, 25600, 16000, 1'b1)};
        rows = {rows, item_row(-300)};
        rows = {rows, item_row(32767)};
        // Above range: upper data bits ignored, then clamp to 64 and 256
        rows = {rows, cfg_row(CFG_SMOOTH_WIN, 9'h1C3)};
        rows = {rows, item_row(1)};
        rows = {rows, item_row(-2)};
        rows = {rows, item_row(4)};
        rows = {rows, cfg_row(CFG_BASE_WIN, 9'd257)};
        rows = {rows, item_row(7)};
        rows = {rows, item_row(-7)};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        after_item = 1'b0;
        foreach (rows[k]) begin
            if (rows[k].is_cfg) begin
                if (after_item) settle();
                write_reg(rows[k].idx, rows[k].data);
                after_item = 1'b0;
            end else begin
                push_sample(rows[k].smp, rows[k].typed, rows[k].gives, rows[k].res);
                after_item = 1'b1;
            end
        end

        // Random phases: short windows, random windows, the largest, then the
        // reset setting with no idling on either side
        run_phase(9'd5, 9'd4, 60, 1'b0);
        run_phase(CFG_DATA_W'($urandom_range(12)),
                  {2'($urandom_range(3)), 7'($urandom_range(10))}, 60, 1'b0);
        run_phase(9'd511, 9'd127, 325, 1'b0);
        run_phase(CFG_DATA_W'(BW_RESET), CFG_DATA_W'(SW_RESET), 160, 1'b1);

        settle();
        if (n_err == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/dsf_pkg.sv
rtl/dsf_div.sv
rtl/dsf_datapath.sv
rtl/dsf_ctrl.sv
rtl/detrend_and_smooth_filter_unit.sv
verif/tb.sv
